// ----- sv/assert_macros.svh -----
// assertion macros shared by the fader rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/cdfr_pkg.sv -----
// types and constants of the cd audio fader
package cdfr_pkg;

	typedef enum logic [0:0] {
		CMD_DATA = 1'b0,
		CMD_GAIN = 1'b1
	} cmd_t;

	localparam logic [15:0] GAIN_RESET   = 16'h4000;
	localparam logic [15:0] TARGET_MASK  = 16'hFFF0;
	localparam logic [14:0] MUL_MASK     = 15'h7FF0;
	localparam logic [15:0] SILENT_LIMIT = 16'd4;
	localparam int          GAIN_SHIFT   = 14;
	localparam int          OUT_W        = 17;
	localparam logic [1:0]  LAST_BYTE    = 2'd3;

	// one assembled stereo frame with the gain to apply
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [14:0]        gain;
	} frame_t;

endpackage

// ----- sv/cdfr_in_if.sv -----
// request channel carrying data bytes and attenuation writes
interface cdfr_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [15:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

// ----- sv/cdfr_out_if.sv -----
// result channel carrying attenuated stereo samples
interface cdfr_out_if;
	logic              valid;
	logic              ready;
	logic signed [16:0] left_out;
	logic signed [16:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- sv/cdfr_ctrl.sv -----
// frame assembly and attenuation ramp control
`include "assert_macros.svh"
module cdfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                cmd,
	input  logic [15:0]         value,
	output logic                frame_vld,
	output cdfr_pkg::frame_t    frame
);

	logic [7:0]  bytes_q [3];
	logic [1:0]  byte_idx_q;
	logic [15:0] cur_gain_q;
	logic [15:0] tgt_gain_q;
	logic [11:0] step_q;

	logic        is_gain;
	logic        is_data;
	logic        last_byte;
	logic [15:0] new_tgt;
	logic [15:0] wr_diff;
	logic        ramp_up;
	logic [15:0] ramp_gap;
	logic        ramp_hit;
	logic [15:0] ramp_gain;

	assign is_gain   = take && (cmd == cdfr_pkg::CMD_GAIN);
	assign is_data   = take && (cmd == cdfr_pkg::CMD_DATA);
	assign last_byte = byte_idx_q == cdfr_pkg::LAST_BYTE;
	assign frame_vld = is_data && last_byte;

	always_comb begin
		new_tgt = value & cdfr_pkg::TARGET_MASK;
		wr_diff = (new_tgt > cur_gain_q) ? (new_tgt - cur_gain_q) : (cur_gain_q - new_tgt);
		// ramp clamps once a step would reach or pass the target
		ramp_up  = tgt_gain_q > cur_gain_q;
		ramp_gap = ramp_up ? (tgt_gain_q - cur_gain_q) : (cur_gain_q - tgt_gain_q);
		ramp_hit = {4'd0, step_q} >= ramp_gap;
		if (ramp_hit) begin
			ramp_gain = tgt_gain_q;
		end else if (ramp_up) begin
			ramp_gain = cur_gain_q + {4'd0, step_q};
		end else begin
			ramp_gain = cur_gain_q - {4'd0, step_q};
		end
	end

	always_comb begin
		frame.left  = $signed({bytes_q[1], bytes_q[0]});
		frame.right = $signed({value[7:0], bytes_q[2]});
		frame.gain  = (cur_gain_q < cdfr_pkg::SILENT_LIMIT) ? '0
			: (cur_gain_q[14:0] & cdfr_pkg::MUL_MASK);
	end

	always_ff @(posedge clk) begin
		if (is_data && !last_byte) begin
			bytes_q[byte_idx_q] <= value[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			cur_gain_q <= cdfr_pkg::GAIN_RESET;
			tgt_gain_q <= cdfr_pkg::GAIN_RESET;
			step_q     <= '0;
		end else if (is_gain) begin
			tgt_gain_q <= new_tgt;
			step_q     <= wr_diff[15:4];
		end else if (is_data) begin
			byte_idx_q <= byte_idx_q + 2'd1;
			if (last_byte && (step_q != '0)) begin
				cur_gain_q <= ramp_gain;
				if (ramp_hit) begin
					step_q <= '0;
				end
			end
		end
	end

	`ASSERT_IMP(a_step_open, clk, arst_n, step_q != '0, cur_gain_q != tgt_gain_q)
	`ASSERT_NXT(a_gain_write, clk, arst_n, is_gain, tgt_gain_q[3:0] == 4'd0)

endmodule

// ----- sv/cdfr_scale.sv -----
// frame register, gain multipliers and result register
`include "assert_macros.svh"
module cdfr_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_vld,
	input  cdfr_pkg::frame_t    frame,
	output logic                ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [16:0]  left_out,
	output logic signed [16:0]  right_out
);

	logic              vld_s1;
	cdfr_pkg::frame_t  frame_s1;
	logic              vld_q;
	logic signed [16:0] left_q;
	logic signed [16:0] right_q;

	logic              move_out;
	logic signed [15:0] gain_s;
	logic signed [31:0] prod_l;
	logic signed [31:0] prod_r;

	assign move_out = !vld_q || out_ready;
	assign ready    = !vld_s1 || move_out;

	assign gain_s = $signed({1'b0, frame_s1.gain});
	assign prod_l = frame_s1.left * gain_s;
	assign prod_r = frame_s1.right * gain_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (ready) begin
				vld_s1 <= frame_vld;
			end
			if (move_out) begin
				vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready && frame_vld) begin
			frame_s1 <= frame;
		end
		// product fits in 31 bits, so the arithmetic shift keeps bits 30..14
		if (move_out && vld_s1) begin
			left_q  <= prod_l[30:cdfr_pkg::GAIN_SHIFT];
			right_q <= prod_r[30:cdfr_pkg::GAIN_SHIFT];
		end
	end

	assign out_valid = vld_q;
	assign left_out  = left_q;
	assign right_out = right_q;

	`ASSERT_NXT(a_s1_moves, clk, arst_n, vld_s1 && move_out, vld_q)
	`ASSERT_NXT(a_bubble_moves, clk, arst_n, !vld_s1 && move_out, !vld_q)
	`ASSERT_NXT(a_silent, clk, arst_n, vld_s1 && move_out && (frame_s1.gain == '0), (left_q == '0) && (right_q == '0))

endmodule

// ----- sv/cd_audio_fader_ramp_top.sv -----
// cd audio fader with attenuation ramp, top level
//
// din takes one request per cycle while ready is high: cmd low carries
// an audio byte in value[7:0], cmd high writes the 16-bit attenuation
// word. four audio bytes (left low, left high, right low, right high)
// form a frame; the fourth byte of each frame gives one result on dout,
// the two samples scaled by bits 14..4 of the current attenuation and
// shifted right by 14. attenuation writes and the first three bytes of
// a frame give no result. after every frame the applied attenuation
// steps toward the written target by a sixteenth of the gap seen at
// write time, and clamps. a result passes from the frame register
// through the multiplier into the result register. throughput: one
// request per cycle while ready is high; ready stays high while the
// result register is free or taken, with the multiplier combinational.
// when dout stalls the frame register fills, then din.ready drops.
// reset clears the byte position and sets attenuation and target to
// 0x4000 with no ramp in progress.
module cd_audio_fader_ramp_top (
	input  logic      clk,
	input  logic      arst_n,
	cdfr_in_if.sink   din,
	cdfr_out_if.source dout
);

	logic             take;
	logic             frame_vld;
	cdfr_pkg::frame_t frame;
	logic             ready;

	assign din.ready = ready;
	assign take      = din.valid && ready;

	cdfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (din.cmd),
		.value     (din.value),
		.frame_vld (frame_vld),
		.frame     (frame)
	);

	cdfr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_vld (frame_vld),
		.frame     (frame),
		.ready     (ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.left_out  (dout.left_out),
		.right_out (dout.right_out)
	);

endmodule

// ----- verif/cd_audio_fader_ramp_top_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the cd audio fader with attenuation ramp
module cd_audio_fader_ramp_top_test;

	localparam int CLK_PERIOD        = 12;
	localparam int TOTAL_REQS        = 1300;
	localparam int SENDER_SLOW_END   = 430;
	localparam int RECEIVER_SLOW_END = 860;
	localparam int HOLD_AT           = 900;
	localparam int HOLD_CYCLES       = 150;
	localparam int STALL_LIMIT       = 3000;
	localparam int DRAIN_CYCLES      = 8;

	typedef struct {
		cdfr_pkg::cmd_t cmd;
		logic [15:0]    value;
	} fader_req_t;

	typedef struct {
		logic signed [16:0] left;
		logic signed [16:0] right;
	} sample_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cdfr_in_if  din_bus ();
	cdfr_out_if dout_bus ();

	cd_audio_fader_ramp_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_bus),
		.dout   (dout_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	fader_req_t   pending_reqs[$];
	sample_pair_t expected_samples[$];
	fader_req_t   next_req;
	sample_pair_t want;

	// predicted fader state
	logic [7:0]  held_bytes [3];
	logic [1:0]  byte_pos;
	logic [15:0] applied_gain;
	logic [15:0] target_gain;
	logic [11:0] gain_step;

	int req_count = 0;
	int frame_count = 0;
	int silent_frames = 0;
	int settled_ramps = 0;
	int gain_writes = 0;
	int fail_count = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	task automatic fade_request(input cdfr_pkg::cmd_t cmd, input logic [15:0] value);
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		int gain_mul;
		int cur;
		int dst;
		sample_pair_t res;
		if (cmd == cdfr_pkg::CMD_GAIN) begin
			target_gain = value & cdfr_pkg::TARGET_MASK;
			if (target_gain > applied_gain)
				gain_step = 12'((target_gain - applied_gain) >> 4);
			else
				gain_step = 12'((applied_gain - target_gain) >> 4);
			gain_writes++;
			return;
		end
		if (byte_pos != cdfr_pkg::LAST_BYTE) begin
			held_bytes[byte_pos] = value[7:0];
			byte_pos++;
			return;
		end
		byte_pos = 2'd0;
		left_in = {held_bytes[1], held_bytes[0]};
		right_in = {value[7:0], held_bytes[2]};
		if (applied_gain < cdfr_pkg::SILENT_LIMIT) begin
			res.left = '0;
			res.right = '0;
			silent_frames++;
		end else begin
			gain_mul = applied_gain & {1'b0, cdfr_pkg::MUL_MASK};
			// floor shift of the full product
			res.left = 17'((int'(left_in) * gain_mul) >>> cdfr_pkg::GAIN_SHIFT);
			res.right = 17'((int'(right_in) * gain_mul) >>> cdfr_pkg::GAIN_SHIFT);
		end
		expected_samples.push_back(res);
		frame_count++;
		if (gain_step != 0) begin
			cur = applied_gain;
			dst = target_gain;
			if (dst > cur) begin
				cur += gain_step;
				if (cur >= dst) begin
					cur = dst;
					gain_step = '0;
					settled_ramps++;
				end
			end else begin
				cur -= gain_step;
				if (cur <= dst) begin
					cur = dst;
					gain_step = '0;
					settled_ramps++;
				end
			end
			applied_gain = 16'(cur);
		end
	endtask

	task automatic push_gain(input logic [15:0] word);
		pending_reqs.push_back('{cmd: cdfr_pkg::CMD_GAIN, value: word});
	endtask

	// one frame of four bytes, optionally with a gain write after split_at bytes
	task automatic push_frame(input logic [15:0] left, input logic [15:0] right,
			input int split_at, input logic [15:0] split_word);
		logic [7:0] frame_bytes [4];
		frame_bytes = '{left[7:0], left[15:8], right[7:0], right[15:8]};
		for (int i = 0; i < 4; i++) begin
			if (split_at == i && split_at != 0)
				push_gain(split_word);
			// junk in the upper bits must be ignored
			pending_reqs.push_back('{cmd: cdfr_pkg::CMD_DATA,
				value: {8'($urandom_range(255)), frame_bytes[i]}});
		end
	endtask

	function automatic logic [15:0] pick_attenuation();
		unique case ($urandom_range(9))
			0, 1: return 16'($urandom_range(15));
			2, 3: return 16'($urandom_range(16'h4F, 16'h10));
			4: return 16'($urandom_range(16'hFFFF, 16'hFFF0));
			5: return 16'h8000 | 16'($urandom_range(15));
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		unique case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			din_bus.valid <= 1'b0;
		end else begin
			if (din_bus.valid && din_bus.ready) begin
				fade_request(cdfr_pkg::cmd_t'(din_bus.cmd), din_bus.value);
				req_count <= req_count + 1;
			end
			if (!din_bus.valid || din_bus.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >=
						((req_count < SENDER_SLOW_END) ? 13 :
						(req_count < RECEIVER_SLOW_END) ? 77 : 0)) begin
					next_req = pending_reqs.pop_front();
					din_bus.valid <= 1'b1;
					din_bus.cmd <= next_req.cmd;
					din_bus.value <= next_req.value;
				end else begin
					din_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			dout_bus.ready <= 1'b0;
		end else begin
			if (dout_bus.valid && dout_bus.ready) begin
				if (expected_samples.size() == 0) begin
					$error("result with no frame pending: left_out %0d right_out %0d",
						dout_bus.left_out, dout_bus.right_out);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (dout_bus.left_out !== want.left) begin
						$error("left_out: expected %0d, got %0d", want.left, dout_bus.left_out);
						fail_count++;
					end
					if (dout_bus.right_out !== want.right) begin
						$error("right_out: expected %0d, got %0d", want.right,
							dout_bus.right_out);
						fail_count++;
					end
				end
			end
			// long hold-off so the block backs up into its input
			if (!hold_done && req_count >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_bus.ready <= 1'b0;
			end else begin
				dout_bus.ready <= $urandom_range(99) >=
					((req_count < SENDER_SLOW_END) ? 77 :
					(req_count < RECEIVER_SLOW_END) ? 13 : 0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (din_bus.valid && din_bus.ready) ||
				(dout_bus.valid && dout_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("cd_audio_fader_ramp_top: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int frames;
		din_bus.valid = 1'b0;
		din_bus.cmd = cdfr_pkg::CMD_DATA;
		din_bus.value = '0;
		dout_bus.ready = 1'b0;
		held_bytes = '{8'h00, 8'h00, 8'h00};
		byte_pos = 2'd0;
		applied_gain = cdfr_pkg::GAIN_RESET;
		target_gain = cdfr_pkg::GAIN_RESET;
		gain_step = '0;

		// full scale at the reset gain
		push_frame(16'h7FFF, 16'h8000, 0, 16'h0000);
		// flag bits dropped, ramp upward
		push_gain(16'hFFFF);
		push_frame(16'h8001, 16'h0001, 0, 16'h0000);
		// write in the middle of a frame, ramp toward zero
		push_frame(16'hFFFF, 16'h7FFF, 2, 16'h0000);
		push_gain(16'h800E);
		push_frame(16'h8000, 16'h7FFF, 0, 16'h0000);
		push_frame(16'h0000, 16'hFFFF, 0, 16'h0000);

		while (pending_reqs.size() < TOTAL_REQS) begin
			push_gain(pick_attenuation());
			// occasional stray byte knocks the frame alignment
			if ($urandom_range(19) == 0)
				pending_reqs.push_back('{cmd: cdfr_pkg::CMD_DATA, value: 16'($urandom)});
			frames = $urandom_range(24, 2);
			for (int f = 0; f < frames; f++)
				push_frame(pick_sample(), pick_sample(),
					($urandom_range(11) == 0) ? $urandom_range(3, 1) : 0,
					pick_attenuation());
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || din_bus.valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d of them attenuation writes", req_count, gain_writes);
		$display("%0d frames checked, %0d silent, %0d ramps settled on target",
			frame_count, silent_frames, settled_ramps);
		if (fail_count == 0)
			$display("cd_audio_fader_ramp_top: match");
		else
			$display("cd_audio_fader_ramp_top: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/cdfr_pkg.sv
sv/cdfr_in_if.sv
sv/cdfr_out_if.sv
sv/cdfr_ctrl.sv
sv/cdfr_scale.sv
sv/cd_audio_fader_ramp_top.sv
verif/cd_audio_fader_ramp_top_test.sv
